FILE: design/tebs_pkg.sv
// Shared types and constants for the triangle edge test and shading core.
package tebs_pkg;

	localparam int unsigned COLOR_BITS = 32;
	localparam int unsigned CHAN_BITS  = 8;
	localparam int unsigned NUM_CHAN   = 4;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [1:0] SLOT_A      = 2'd0;
	localparam logic [1:0] SLOT_B      = 2'd1;
	localparam logic [1:0] SLOT_C      = 2'd2;
	localparam logic [1:0] SLOT_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

FILE: design/tebs_front.sv
// Front part: stores corners, forms edge products and coverage, queues pixel jobs.
module tebs_front import tebs_pkg::*; #(
	parameter int unsigned CB = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_cmd,
	input  logic [1:0]            in_slot,
	input  logic signed [CB-1:0]  in_x,
	input  logic signed [CB-1:0]  in_y,
	input  logic [COLOR_BITS-1:0] in_color,
	output logic                  job_valid,
	input  logic                  job_ready,
	output logic                  job_cov,
	output logic                  job_deg,
	output logic [CB-1:0]         job_x,
	output logic [CB-1:0]         job_y,
	output logic [2*CB+1:0]       job_wa,
	output logic [2*CB+1:0]       job_wb,
	output logic [2*CB+1:0]       job_wc,
	output logic [2*CB+1:0]       job_area,
	output logic [COLOR_BITS-1:0] job_ca,
	output logic [COLOR_BITS-1:0] job_cb,
	output logic [COLOR_BITS-1:0] job_cc
);

	localparam int unsigned DW = CB + 1;
	localparam int unsigned PW = 2 * CB + 2;

	logic signed [CB-1:0] cx_q [3];
	logic signed [CB-1:0] cy_q [3];
	logic [COLOR_BITS-1:0] cc_q [3];

	// stage 1: differences
	logic                 v_s1;
	logic signed [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1, qx_s1, qy_s1;
	logic [CB-1:0]        px_s1, py_s1;
	// Corner colors travel with the pixel so that a later load cannot change them.
	logic [COLOR_BITS-1:0] ca_s1, cb_s1, cc_s1;
	// stage 2: products
	logic                 v_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [PW-1:0] a1_s2, a2_s2;
	logic [CB-1:0]        px_s2, py_s2;
	logic [COLOR_BITS-1:0] ca_s2, cb_s2, cc_s2;

	logic stall;
	assign stall = job_valid && !job_ready;
	assign in_ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				cx_q[i] <= '0;
				cy_q[i] <= '0;
				cc_q[i] <= '0;
			end
		end else if (in_valid && in_ready && in_cmd == CMD_LOAD && in_slot != SLOT_UNUSED) begin
			cx_q[in_slot] <= in_x;
			cy_q[in_slot] <= in_y;
			cc_q[in_slot] <= in_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			job_valid <= 1'b0;
		end else if (!stall) begin
			v_s1      <= in_valid && in_cmd == CMD_PIXEL;
			v_s2      <= v_s1;
			job_valid <= v_s2;
		end
	end

	logic signed [PW-1:0] e_ab, e_bc, e_ca, e_ar;
	assign e_ab = p1_s2 - p2_s2;
	assign e_bc = p3_s2 - p4_s2;
	assign e_ca = p5_s2 - p6_s2;
	assign e_ar = a1_s2 - a2_s2;

	function automatic logic [PW-1:0] mag(input logic signed [PW-1:0] v);
		return v[PW-1] ? PW'(-v) : PW'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (!stall) begin
			ax_s1 <= DW'(cx_q[0]) - DW'(in_x);
			ay_s1 <= DW'(cy_q[0]) - DW'(in_y);
			bx_s1 <= DW'(cx_q[1]) - DW'(in_x);
			by_s1 <= DW'(cy_q[1]) - DW'(in_y);
			qx_s1 <= DW'(cx_q[2]) - DW'(in_x);
			qy_s1 <= DW'(cy_q[2]) - DW'(in_y);
			px_s1 <= in_x;
			py_s1 <= in_y;
			ca_s1 <= cc_q[0];
			cb_s1 <= cc_q[1];
			cc_s1 <= cc_q[2];
			p1_s2 <= PW'(ax_s1 * by_s1);
			p2_s2 <= PW'(ay_s1 * bx_s1);
			p3_s2 <= PW'(bx_s1 * qy_s1);
			p4_s2 <= PW'(by_s1 * qx_s1);
			p5_s2 <= PW'(qx_s1 * ay_s1);
			p6_s2 <= PW'(qy_s1 * ax_s1);
			a1_s2 <= PW'((bx_s1 - ax_s1) * (qy_s1 - ay_s1));
			a2_s2 <= PW'((by_s1 - ay_s1) * (qx_s1 - ax_s1));
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			ca_s2 <= ca_s1;
			cb_s2 <= cb_s1;
			cc_s2 <= cc_s1;
			job_cov  <= (!e_ab[PW-1] && !e_bc[PW-1] && !e_ca[PW-1]) ||
				((e_ab[PW-1] || e_ab == '0) && (e_bc[PW-1] || e_bc == '0) &&
				 (e_ca[PW-1] || e_ca == '0));
			job_deg  <= e_ar == '0;
			job_wa   <= mag(e_bc);
			job_wb   <= mag(e_ca);
			job_wc   <= mag(e_ab);
			job_area <= mag(e_ar);
			job_x    <= px_s2;
			job_y    <= py_s2;
			job_ca   <= ca_s2;
			job_cb   <= cb_s2;
			job_cc   <= cc_s2;
		end
	end

endmodule

FILE: design/tebs_back.sv
// Back part: weighted channel sums and a restoring divider per pixel.
module tebs_back import tebs_pkg::*; #(
	parameter int unsigned CB = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  logic                  job_cov,
	input  logic                  job_deg,
	input  logic [CB-1:0]         job_x,
	input  logic [CB-1:0]         job_y,
	input  logic [2*CB+1:0]       job_wa,
	input  logic [2*CB+1:0]       job_wb,
	input  logic [2*CB+1:0]       job_wc,
	input  logic [2*CB+1:0]       job_area,
	input  logic [COLOR_BITS-1:0] job_ca,
	input  logic [COLOR_BITS-1:0] job_cb,
	input  logic [COLOR_BITS-1:0] job_cc,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COLOR_BITS+2*CB+1:0] out_data
);

	localparam int unsigned PW = 2 * CB + 2;
	localparam int unsigned NW = PW + CHAN_BITS + 2;
	// Quotient never exceeds 255 for covered pixels, so 8 restoring steps suffice.
	localparam int unsigned QB = CHAN_BITS;

	bk_state_t state_q, state_d;
	logic [1:0] ch_q;
	logic [$clog2(QB+1)-1:0] bit_q;
	logic [PW-1:0] wa_q, wb_q, wc_q, area_q;
	logic [COLOR_BITS-1:0] ca_q, cb_q, cc_q, col_q;
	logic [NW-1:0] rem_q;
	logic [CHAN_BITS-1:0] quo_q;
	logic cov_q, deg_q;
	logic [CB-1:0] x_q, y_q;

	logic [CHAN_BITS-1:0] ea, eb, ec;
	assign ea = ca_q[ch_q*CHAN_BITS +: CHAN_BITS];
	assign eb = cb_q[ch_q*CHAN_BITS +: CHAN_BITS];
	assign ec = cc_q[ch_q*CHAN_BITS +: CHAN_BITS];

	logic [NW-1:0] trial, sh_rem, dsh;
	assign dsh    = NW'(area_q) << bit_q;
	assign sh_rem = rem_q;
	assign trial  = sh_rem - dsh;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job_valid) state_d = BK_MUL;
			BK_MUL:  state_d = (cov_q && !deg_q) ? BK_DIV : BK_OUT;
			BK_DIV:  if (bit_q == '0) state_d = (ch_q == 2'd3) ? BK_OUT : BK_MUL;
			BK_OUT:  if (!out_valid || out_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == BK_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q == BK_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				wa_q <= job_wa; wb_q <= job_wb; wc_q <= job_wc; area_q <= job_area;
				ca_q <= job_ca; cb_q <= job_cb; cc_q <= job_cc;
				cov_q <= job_cov; deg_q <= job_deg; x_q <= job_x; y_q <= job_y;
				ch_q <= '0; col_q <= '0;
			end
			BK_MUL: begin
				rem_q <= NW'(wa_q * ea) + NW'(wb_q * eb) + NW'(wc_q * ec);
				bit_q <= ($bits(bit_q))'(QB - 1);
				quo_q <= '0;
			end
			BK_DIV: begin
				if (!trial[NW-1] && sh_rem >= dsh) begin
					rem_q <= trial;
					quo_q[bit_q[$clog2(QB)-1:0]] <= 1'b1;
				end
				if (bit_q == '0) begin
					col_q[ch_q*CHAN_BITS +: CHAN_BITS] <=
						quo_q | ((!trial[NW-1] && sh_rem >= dsh) ? CHAN_BITS'(1) : '0);
					ch_q <= ch_q + 2'd1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
			BK_OUT: begin
				if (!out_valid || out_ready)
					out_data <= {col_q, y_q, x_q, deg_q, cov_q};
			end
			default: ;
		endcase
	end

endmodule

FILE: design/triangle_edge_test_bary_shade_core.sv
// Top level of the triangle edge test and barycentric shading core.
// Usage: the s_axis channel takes beats that either load a triangle corner
// (command 0, slot 0..2 for A, B, C; slot 3 is ignored) or test one pixel
// (command 1). Loads give no output beat; each pixel beat gives exactly one
// m_axis beat with coverage, degenerate flag, echoed position and color.
// The front pipeline (three stages) forms the edge products and the area;
// a pixel then waits in a one-entry queue for the back part, which makes
// four channel passes of a multiply-accumulate step and an eight-step
// restoring divide. A covered pixel occupies the back part for all passes,
// an uncovered or degenerate one skips the divide; the back part sets the rate.
// Corner loads pass the front at one beat per cycle unless it is stalled.
// Reset clears all corners to zero and empties every stage.
// When the receiver stalls, the output register holds its beat and the
// stall propagates back through the queue to s_axis_tready.
// With nothing queued ahead, a covered pixel raises m_axis_tvalid later than
// an uncovered or degenerate one, since only a covered pixel takes the
// divide passes in the back part.
module triangle_edge_test_bary_shade_core import tebs_pkg::*; #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: command, vertex_slot, pos_x, pos_y, vertex_color, zero fill
	input  logic [((3+2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata: covered, degenerate, frag_x, frag_y, frag_color, zero fill
	output logic [((2+2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata
);

	localparam int unsigned CB = COORD_BITS;
	localparam int unsigned OW = 2 + 2 * CB + COLOR_BITS;
	localparam int unsigned OT = ((OW + 7) / 8) * 8;

	logic                  job_valid, job_ready, job_cov, job_deg;
	logic [CB-1:0]         job_x, job_y;
	logic [2*CB+1:0]       job_wa, job_wb, job_wc, job_area;
	logic [COLOR_BITS-1:0] job_ca, job_cb, job_cc;
	logic [OW-1:0]         out_data;

	tebs_front #(.CB(CB)) u_front (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tdata[0]),
		.in_slot  (s_axis_tdata[2:1]),
		.in_x     (s_axis_tdata[3 +: CB]),
		.in_y     (s_axis_tdata[3+CB +: CB]),
		.in_color (s_axis_tdata[3+2*CB +: COLOR_BITS]),
		.job_valid, .job_ready, .job_cov, .job_deg, .job_x, .job_y,
		.job_wa, .job_wb, .job_wc, .job_area, .job_ca, .job_cb, .job_cc
	);

	tebs_back #(.CB(CB)) u_back (
		.clk, .arst_n,
		.job_valid, .job_ready, .job_cov, .job_deg, .job_x, .job_y,
		.job_wa, .job_wb, .job_wc, .job_area, .job_ca, .job_cb, .job_cc,
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign m_axis_tdata = OT'(out_data);

endmodule

FILE: tb/tb_triangle_edge_test_bary_shade_core.sv
// Self-checking testbench for the triangle edge test and barycentric shading core.
`timescale 1ns / 1ps

module tb_triangle_edge_test_bary_shade_core import tebs_pkg::*; ();

	localparam int CB = 12;
	localparam int IN_W = ((3 + 2*CB + COLOR_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((2 + 2*CB + COLOR_BITS + 7) / 8) * 8;
	localparam longint CYCLE_LIMIT = 3000000;

	// Fields of one input beat and of one fragment.
	typedef struct packed {
		logic            command;
		logic [1:0]      slot;
		logic [CB-1:0]   x;
		logic [CB-1:0]   y;
		logic [31:0]     color;
	} item_t;

	typedef struct packed {
		logic            covered;
		logic            degenerate;
		logic [CB-1:0]   x;
		logic [CB-1:0]   y;
		logic [31:0]     color;
	} frag_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	triangle_edge_test_bary_shade_core #(.COORD_BITS(CB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of the three stored corners.
	logic [CB-1:0] shadow_x [3];
	logic [CB-1:0] shadow_y [3];
	logic [31:0]   shadow_color [3];

	frag_t pending_frags [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Packs the fields with command in the lowest bit.
	function automatic logic [IN_W-1:0] pack_item(item_t it);
		logic [IN_W-1:0] d;
		d = '0;
		d[0] = it.command;
		d[2:1] = it.slot;
		d[3 +: CB] = it.x;
		d[3+CB +: CB] = it.y;
		d[3+2*CB +: 32] = it.color;
		return d;
	endfunction

	function automatic frag_t unpack_frag(logic [OUT_W-1:0] d);
		frag_t f;
		f.covered = d[0];
		f.degenerate = d[1];
		f.x = d[2 +: CB];
		f.y = d[2+CB +: CB];
		f.color = d[2+2*CB +: 32];
		return f;
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Updates the corner copy on a load and returns the shaded fragment on a pixel.
	function automatic bit shade_pixel(item_t it, output frag_t f);
		longint ax, ay, bx, by, cx, cy, px, py, ab, bc, ca, area, wa, wb, wc, ch;
		logic [31:0] col;
		f = '0;
		if (it.command == CMD_LOAD) begin
			if (it.slot != SLOT_UNUSED) begin
				shadow_x[it.slot] = it.x;
				shadow_y[it.slot] = it.y;
				shadow_color[it.slot] = it.color;
			end
			return 0;
		end
		px = longint'($signed(it.x));
		py = longint'($signed(it.y));
		ax = longint'($signed(shadow_x[0])) - px;
		ay = longint'($signed(shadow_y[0])) - py;
		bx = longint'($signed(shadow_x[1])) - px;
		by = longint'($signed(shadow_y[1])) - py;
		cx = longint'($signed(shadow_x[2])) - px;
		cy = longint'($signed(shadow_y[2])) - py;
		ab = ax * by - ay * bx;
		bc = bx * cy - by * cx;
		ca = cx * ay - cy * ax;
		area = abs64((bx - ax) * (cy - ay) - (by - ay) * (cx - ax));
		f.covered = (ab >= 0 && bc >= 0 && ca >= 0) || (ab <= 0 && bc <= 0 && ca <= 0);
		f.degenerate = (area == 0);
		f.x = it.x;
		f.y = it.y;
		col = '0;
		if (f.covered && !f.degenerate) begin
			wa = abs64(bc);
			wb = abs64(ca);
			wc = abs64(ab);
			for (int c = 0; c < NUM_CHAN; c++) begin
				ch = (wa * shadow_color[0][8*c +: 8] + wb * shadow_color[1][8*c +: 8]
					+ wc * shadow_color[2][8*c +: 8]) / area;
				if (ch > 255) ch = 255;
				col[8*c +: 8] = ch[7:0];
			end
		end
		f.color = col;
		return 1;
	endfunction

	// Receiver side: random stalls and the in-order check of every fragment.
	always @(posedge clk) begin
		frag_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = unpack_frag(m_axis_tdata);
				if (pending_frags.size() == 0) begin
					$display("%0t: unexpected fragment %h", $time, got);
					errors++;
				end else begin
					want = pending_frags.pop_front();
					if (got.covered !== want.covered) begin
						$display("%0t: covered expected %b actual %b", $time,
							want.covered, got.covered);
						errors++;
					end
					if (got.degenerate !== want.degenerate) begin
						$display("%0t: degenerate expected %b actual %b", $time,
							want.degenerate, got.degenerate);
						errors++;
					end
					if (got.x !== want.x || got.y !== want.y) begin
						$display("%0t: position expected %h,%h actual %h,%h", $time,
							want.x, want.y, got.x, got.y);
						errors++;
					end
					if (got.color !== want.color) begin
						$display("%0t: color expected %h actual %h", $time,
							want.color, got.color);
						errors++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end else begin
			m_axis_tready <= 1'b0;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Drives one beat and holds it until accepted; queues any expected fragment.
	// Valid stays high after the beat unless the next call idles first.
	task automatic send_item(item_t it);
		frag_t f;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		s_axis_tdata <= pack_item(it);
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (shade_pixel(it, f)) pending_frags.insert(pending_frags.size(), f);
	endtask

	function automatic item_t make_item(logic cmd, logic [1:0] slot, int x, int y,
			logic [31:0] color);
		item_t it;
		it.command = cmd;
		it.slot = slot;
		it.x = x[CB-1:0];
		it.y = y[CB-1:0];
		it.color = color;
		return it;
	endfunction

	// Random coordinate: mostly a small window so pixels often land inside.
	function automatic int rand_coord();
		if ($urandom_range(9) == 0) return $urandom_range(4095) - 2048;
		return $urandom_range(64) - 32;
	endfunction

	// Directed table. A clear has_exp flag means the row is checked by the predictor;
	// rows with has_exp set must also match the typed-in fragment.
	typedef struct {
		item_t it;
		bit    has_exp;
		frag_t exp_frag;
	} row_t;

	row_t directed [$];

	task automatic add_row(item_t it, bit has_exp, frag_t ef);
		row_t r;
		r.it = it;
		r.has_exp = has_exp;
		r.exp_frag = ef;
		directed.insert(directed.size(), r);
	endtask

	initial begin
		frag_t ef;
		item_t it;
		int n_frags;
		int phase;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		for (int i = 0; i < 3; i++) begin
			shadow_x[i] = '0;
			shadow_y[i] = '0;
			shadow_color[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every corner sits at the origin: degenerate, covered, black.
		add_row(make_item(CMD_PIXEL, SLOT_A, 0, 0, 32'h0), 1, '{1'b1, 1'b1, 12'h000,
			12'h000, 32'h0});
		// All corners coincide, so every edge product is zero and the pixel counts as covered.
		add_row(make_item(CMD_PIXEL, SLOT_UNUSED, 2047, -2048, 32'hFFFF_FFFF), 1,
			'{1'b1, 1'b1, 12'h7FF, 12'h800, 32'h0});
		// Right triangle with primary colors; a pixel on corner A returns A's color.
		add_row(make_item(CMD_LOAD, SLOT_A, 0, 0, 32'hFFFF_0000), 0, '0);
		add_row(make_item(CMD_LOAD, SLOT_B, 100, 0, 32'h00FF_FF00), 0, '0);
		add_row(make_item(CMD_LOAD, SLOT_C, 0, 100, 32'h0000_FFFF), 0, '0);
		add_row(make_item(CMD_PIXEL, SLOT_A, 0, 0, 32'h0), 1,
			'{1'b1, 1'b0, 12'h000, 12'h000, 32'hFFFF_0000});
		add_row(make_item(CMD_PIXEL, SLOT_A, 50, 50, 32'h0), 0, '0);
		add_row(make_item(CMD_PIXEL, SLOT_A, 33, 33, 32'h0), 0, '0);
		// Outside the triangle: no color.
		add_row(make_item(CMD_PIXEL, SLOT_A, 51, 51, 32'h0), 1,
			'{1'b0, 1'b0, 12'd51, 12'd51, 32'h0});
		// Load to the unused slot must not disturb corner A.
		add_row(make_item(CMD_LOAD, SLOT_UNUSED, 1000, 1000, 32'h1234_5678), 0, '0);
		add_row(make_item(CMD_PIXEL, SLOT_A, 0, 0, 32'h0), 1,
			'{1'b1, 1'b0, 12'h000, 12'h000, 32'hFFFF_0000});
		// Full-range triangle at the coordinate extremes.
		add_row(make_item(CMD_LOAD, SLOT_A, -2048, -2048, 32'hFFFF_FFFF), 0, '0);
		add_row(make_item(CMD_LOAD, SLOT_B, 2047, -2048, 32'h8040_2010), 0, '0);
		add_row(make_item(CMD_LOAD, SLOT_C, -2048, 2047, 32'h0000_0000), 0, '0);
		add_row(make_item(CMD_PIXEL, SLOT_A, -2048, -2048, 32'h0), 1,
			'{1'b1, 1'b0, 12'h800, 12'h800, 32'hFFFF_FFFF});
		add_row(make_item(CMD_PIXEL, SLOT_A, 0, 0, 32'h0), 0, '0);
		add_row(make_item(CMD_PIXEL, SLOT_A, 2047, 2047, 32'h0), 0, '0);
		add_row(make_item(CMD_PIXEL, SLOT_A, -1, -1, 32'hFFFF_FFFF), 0, '0);
		// Collinear corners: degenerate with the edge test still reported.
		add_row(make_item(CMD_LOAD, SLOT_C, 4, 4, 32'h0), 0, '0);
		add_row(make_item(CMD_LOAD, SLOT_B, 2, 2, 32'h0), 0, '0);
		add_row(make_item(CMD_LOAD, SLOT_A, 0, 0, 32'h0), 0, '0);
		add_row(make_item(CMD_PIXEL, SLOT_A, 3, 3, 32'h0), 1,
			'{1'b1, 1'b1, 12'd3, 12'd3, 32'h0});
		add_row(make_item(CMD_PIXEL, SLOT_A, 3, 1, 32'h0), 0, '0);

		foreach (directed[i]) begin
			send_item(directed[i].it);
			if (directed[i].has_exp && directed[i].it.command == CMD_PIXEL) begin
				ef = pending_frags[pending_frags.size()-1];
				if (ef !== directed[i].exp_frag) begin
					$display("%0t: row %0d expected %h actual %h", $time, i,
						directed[i].exp_frag, ef);
					errors++;
				end
			end
		end

		// Random part: mostly full triangle loads followed by pixels inside its window.
		for (phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			n_frags = 0;
			while (n_frags < 320) begin
				if ($urandom_range(9) < 8) begin
					for (int s = 0; s < 3; s++)
						send_item(make_item(CMD_LOAD, s[1:0], rand_coord(), rand_coord(),
							$urandom()));
				end else begin
					it = make_item(CMD_LOAD, 2'($urandom_range(3)), rand_coord(),
						rand_coord(), $urandom());
					send_item(it);
				end
				for (int p = $urandom_range(1, 8); p > 0; p--) begin
					send_item(make_item(CMD_PIXEL, 2'($urandom_range(3)), rand_coord(),
						rand_coord(), $urandom()));
					n_frags++;
				end
			end
			// After phase 1 the sender holds off until the core has drained every fragment.
			if (phase == 1) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_frags.size() != 0) @(posedge clk);
			end
		end
		recv_stall_pct = 0;

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_frags.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending_frags.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
